FILE: src/dtw_pkg.sv
// Package for the deadband thermostat: widths, reset values and result codes.
`timescale 1ns / 1ps

package dtw_pkg;

    // Sample width in bits (signed, 1/16 degree units), at least 12 so that the read-fail mark fits
    localparam int TEMP_WIDTH = 12;

    // Configuration register widths
    localparam int TARGET_W = 12;
    localparam int BAND_W   = 10;
    localparam int TICK_W   = 8;
    localparam int WD_W     = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    // Width for the differences: the wider operand plus sign and carry
    localparam int DIFF_W = ((TEMP_WIDTH > TARGET_W) ? TEMP_WIDTH : TARGET_W) + 2;

    // Sample value that marks a failed sensor read
    localparam int READ_FAIL_MARK = -2032;

    // Reset values of the configuration registers and the watchdog
    localparam logic signed [TARGET_W-1:0] TARGET_RESET   = 12'sd416;
    localparam logic        [BAND_W-1:0]   BAND_RESET     = 10'd32;
    localparam logic        [TICK_W-1:0]   FAN_ON_RESET   = 8'd1;
    localparam logic        [TICK_W-1:0]   FAN_OFF_RESET  = 8'd2;
    localparam logic        [WD_W-1:0]     WD_RELOAD_RESET = 8'd60;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET_TEMP     = 3'd0,
        CFG_DEADBAND        = 3'd1,
        CFG_FAN_ON_TICKS    = 3'd2,
        CFG_FAN_OFF_TICKS   = 3'd3,
        CFG_WATCHDOG_RELOAD = 3'd4,
        CFG_SEPARATE_COOLER = 3'd5
    } cfg_index_t;

    // Control action reported with each result
    typedef enum logic [1:0] {
        ACT_NONE = 2'd0,
        ACT_STOP = 2'd1,
        ACT_HEAT = 2'd2,
        ACT_COOL = 2'd3
    } action_t;

    // Watchdog status reported with each result
    typedef enum logic [1:0] {
        WD_OK        = 2'd0,
        WD_WAIT      = 2'd1,
        WD_HEAT_FAIL = 2'd2,
        WD_COOL_FAIL = 2'd3
    } wd_status_t;

endpackage

FILE: src/deadband_thermostat_with_watchdog.sv
// Top level of the deadband thermostat with heater/fan control and watchdog.
`timescale 1ns / 1ps

// Bang-bang thermostat with hysteresis. Each transaction on the s_ channel is
// one temperature sample (signed, 1/16 degree); each produces exactly one
// result on the m_ channel with the relay levels, the control action, the
// watchdog status and a read-failure flag. The block takes one sample per
// clock unless m_ready holds back a result: a sample is captured in the input
// register, and the controller state and the result register update together
// at the first edge on which the result slot is free, which raises m_valid.
// Back-pressure on m_ready holds one result in the output register and one
// sample in the input register. Configuration registers are written through
// cfg_wr_en/cfg_index/cfg_wdata and should only change while no transaction
// is in flight.
module deadband_thermostat_with_watchdog (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    // configuration write port
    input  logic                                    cfg_wr_en,
    input  logic [dtw_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  logic [dtw_pkg::CFG_DATA_W-1:0]          cfg_wdata,
    // sample channel
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic signed [dtw_pkg::TEMP_WIDTH-1:0]   s_sample,
    // result channel
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic                                    m_heater_drive,
    output logic                                    m_fan_drive,
    output logic [1:0]                              m_control_action,
    output logic [1:0]                              m_watchdog_status,
    output logic                                    m_read_failed
);
    import dtw_pkg::*;

    // configuration registers
    logic signed [TARGET_W-1:0] target_temp_reg;
    logic [BAND_W-1:0]          deadband_reg;
    logic [TICK_W-1:0]          fan_on_ticks_reg;
    logic [TICK_W-1:0]          fan_off_ticks_reg;
    logic [WD_W-1:0]            watchdog_reload_reg;
    logic                       separate_cooler_reg;

    // input stage
    logic                         in_valid_reg;
    logic signed [TEMP_WIDTH-1:0] in_sample_reg;

    // controller state
    logic              heating_reg, heating_next;
    logic              cooling_reg, cooling_next;
    logic              fan_reg, fan_next;
    logic              phase_on_reg, phase_on_next;
    logic [TICK_W-1:0] duty_count_reg, duty_count_next;
    logic [WD_W-1:0]   wd_left_reg, wd_left_next;

    // result register
    logic       out_valid_reg;
    logic       out_heater_reg;
    logic       out_fan_reg;
    action_t    out_action_reg, action_next;
    wd_status_t out_wd_reg, wd_next;
    logic       out_failed_reg;

    // comparison datapath
    logic signed [DIFF_W-1:0] t_ext, target_ext, band_ext, diff, ndiff;
    logic                     below, above, failed;
    logic [TICK_W-1:0]        duty_limit;
    logic                     out_load;

    // handshake: the input register moves on whenever the result slot frees
    assign out_load = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready  = !in_valid_reg || out_load;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_temp_reg     <= TARGET_RESET;
            deadband_reg        <= BAND_RESET;
            fan_on_ticks_reg    <= FAN_ON_RESET;
            fan_off_ticks_reg   <= FAN_OFF_RESET;
            watchdog_reload_reg <= WD_RELOAD_RESET;
            separate_cooler_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_TARGET_TEMP:     target_temp_reg     <= signed'(cfg_wdata[TARGET_W-1:0]);
                CFG_DEADBAND:        deadband_reg        <= cfg_wdata[BAND_W-1:0];
                CFG_FAN_ON_TICKS:    fan_on_ticks_reg    <= cfg_wdata[TICK_W-1:0];
                CFG_FAN_OFF_TICKS:   fan_off_ticks_reg   <= cfg_wdata[TICK_W-1:0];
                CFG_WATCHDOG_RELOAD: watchdog_reload_reg <= cfg_wdata[WD_W-1:0];
                CFG_SEPARATE_COOLER: separate_cooler_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            in_sample_reg <= s_sample;
        end
    end

    // sample versus target, both directions
    always_comb begin
        t_ext      = DIFF_W'(in_sample_reg);
        target_ext = DIFF_W'(target_temp_reg);
        band_ext   = DIFF_W'(signed'({1'b0, deadband_reg}));
        diff       = t_ext - target_ext;
        ndiff      = target_ext - t_ext;
        below      = ndiff > band_ext;
        above      = diff > band_ext;
        failed     = (t_ext == DIFF_W'(READ_FAIL_MARK));
        duty_limit = phase_on_reg ? fan_on_ticks_reg : fan_off_ticks_reg;
    end

    // controller and watchdog next state
    always_comb begin
        heating_next    = heating_reg;
        cooling_next    = cooling_reg;
        fan_next        = fan_reg;
        phase_on_next   = phase_on_reg;
        duty_count_next = duty_count_reg;
        wd_left_next    = wd_left_reg;
        action_next     = ACT_NONE;
        wd_next         = WD_OK;

        if (!failed) begin
            if (below) begin
                if (!heating_reg) begin
                    if (separate_cooler_reg) begin
                        fan_next     = 1'b0;
                        cooling_next = 1'b0;
                    end else begin
                        // fan duty cycle steps on every heater start
                        if (duty_count_reg < duty_limit) begin
                            duty_count_next = duty_count_reg + 1'b1;
                        end else begin
                            duty_count_next = '0;
                            phase_on_next   = !phase_on_reg;
                            fan_next        = !phase_on_reg;
                        end
                        cooling_next = 1'b1;
                    end
                    heating_next = 1'b1;
                    action_next  = ACT_HEAT;
                end
            end else if (above) begin
                if (!cooling_reg) begin
                    heating_next = 1'b0;
                    fan_next     = 1'b1;
                    cooling_next = 1'b1;
                    action_next  = ACT_COOL;
                end
            end else if (heating_reg || cooling_reg) begin
                heating_next = 1'b0;
                cooling_next = 1'b0;
                fan_next     = 1'b0;
                action_next  = ACT_STOP;
            end
        end

        // watchdog runs on every sample, failed reads included
        if (below || above) begin
            if (wd_left_reg == '0) begin
                wd_next = diff[DIFF_W-1] ? WD_HEAT_FAIL : WD_COOL_FAIL;
            end else begin
                wd_left_next = wd_left_reg - 1'b1;
                wd_next      = WD_WAIT;
            end
        end else begin
            wd_left_next = watchdog_reload_reg;
            wd_next      = WD_OK;
        end
    end

    // state and result registers update together
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            heating_reg    <= 1'b0;
            cooling_reg    <= 1'b0;
            fan_reg        <= 1'b0;
            phase_on_reg   <= 1'b1;
            duty_count_reg <= '0;
            wd_left_reg    <= WD_RELOAD_RESET;
            out_valid_reg  <= 1'b0;
        end else begin
            if (out_load) begin
                heating_reg    <= heating_next;
                cooling_reg    <= cooling_next;
                fan_reg        <= fan_next;
                phase_on_reg   <= phase_on_next;
                duty_count_reg <= duty_count_next;
                wd_left_reg    <= wd_left_next;
                out_valid_reg  <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg  <= 1'b0;
            end
        end
        if (out_load) begin
            out_heater_reg <= heating_next;
            out_fan_reg    <= fan_next;
            out_action_reg <= action_next;
            out_wd_reg     <= wd_next;
            out_failed_reg <= failed;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_heater_drive    = out_heater_reg;
    assign m_fan_drive       = out_fan_reg;
    assign m_control_action  = out_action_reg;
    assign m_watchdog_status = out_wd_reg;
    assign m_read_failed     = out_failed_reg;

    // a heater start always leaves the heater on
    a_heat_drives: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && (out_action_reg == ACT_HEAT) |-> out_heater_reg)
        else $error("heating started but heater is off");

    // a cooling start always leaves the heater off and the fan on
    a_cool_drives: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && (out_action_reg == ACT_COOL) |-> !out_heater_reg && out_fan_reg)
        else $error("cooling started with wrong relay levels");

    // a failed read never causes a control action
    a_fail_no_action: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_failed_reg |-> (out_action_reg == ACT_NONE))
        else $error("control action on failed read");

    // a failure report only comes with an exhausted watchdog count
    a_wd_exhausted: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && ((out_wd_reg == WD_HEAT_FAIL) || (out_wd_reg == WD_COOL_FAIL))
        |-> (wd_left_reg == '0))
        else $error("watchdog failure with count left");

    // while a result is not taken, the watchdog count and heating state do not move under it
    a_hold_state: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_ready |=> $stable(wd_left_reg) && $stable(heating_reg))
        else $error("controller state moved while result stalled");

endmodule
